@@ sv/fpr_pkg.sv @@
// ----------------------------------------------------------------------------
// fpr_pkg
// Shared constants and types for the fifo page replacement block.
// ----------------------------------------------------------------------------
package fpr_pkg;

	// sizing
	localparam int MAX_FRAMES = 8;
	localparam int PAGE_BITS  = 16;
	localparam int FIDX_W     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int CFG_W      = 4;
	localparam int NCNT_W     = ($clog2(MAX_FRAMES + 1) > CFG_W) ?
		$clog2(MAX_FRAMES + 1) : CFG_W;

	// result field widths
	localparam int OUT_IDX_W = 3;
	localparam int OUT_PG_W  = 16;
	localparam int COUNT_W   = 16;
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	// packed result beat: fields from the lowest bit up
	localparam int RES_BITS = 1 + OUT_IDX_W + 1 + OUT_PG_W + 2 * COUNT_W;
	localparam int RES_W    = ((RES_BITS + 7) / 8) * 8;
	localparam int IN_W     = ((PAGE_BITS + 7) / 8) * 8;

	// configuration register map
	localparam int APB_AW = 3;
	localparam logic REG_FRAMES_IN_USE = 1'b0;

	// search and victim information handed from cell to cell
	typedef struct packed {
		logic              found;
		logic [FIDX_W-1:0] hit_slot;
		logic              ev_valid;
		logic [PAGE_BITS-1:0] ev_page;
	} chain_t;

	// per-cell control from the top level
	typedef struct packed {
		logic              active;
		logic              victim;
		logic              load;
		logic [FIDX_W-1:0] idx;
	} cell_ctrl_t;

endpackage

@@ sv/fpr_cell.sv @@
// ----------------------------------------------------------------------------
// fpr_cell
// One page frame: holds a page and its valid bit, joins the priority search
// and offers its contents as eviction candidate.
// ----------------------------------------------------------------------------
module fpr_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  fpr_pkg::cell_ctrl_t          ctrl,
	input  logic [fpr_pkg::PAGE_BITS-1:0] page,
	input  fpr_pkg::chain_t              chain_in,
	output fpr_pkg::chain_t              chain_out
);

	logic [fpr_pkg::PAGE_BITS-1:0] page_q;
	logic                          valid_q;
	logic                          match;

	// frame storage, loaded on a fault that picks this frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.load) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			page_q <= page;
		end
	end

	// lowest matching frame wins: an earlier find passes straight through
	assign match = ctrl.active && valid_q && (page_q == page);

	always_comb begin
		chain_out = chain_in;
		if (!chain_in.found && match) begin
			chain_out.found    = 1'b1;
			chain_out.hit_slot = ctrl.idx;
		end
		if (ctrl.victim) begin
			chain_out.ev_valid = valid_q;
			chain_out.ev_page  = valid_q ? page_q : '0;
		end
	end

endmodule

@@ sv/fifo_page_replacement.sv @@
// ----------------------------------------------------------------------------
// fifo_page_replacement
// FIFO page replacement unit built as a row of frame cells.
// ----------------------------------------------------------------------------
// Each beat on the slave side carries one page reference; one result beat
// follows for each. The page is looked up in all active frames at once along
// the row of frame cells, so a reference is resolved in the cycle it is taken
// and its result is captured in the output register; with the output side
// ready the block takes one reference every cycle. A fault fills the frame
// named by the round-robin replace pointer. frames_in_use is written over the
// APB port at address 0; the user must write it only while the block is idle,
// as the block does not enforce this. 0 acts as 1 and values above the frame
// count act as the frame count.
module fifo_page_replacement (
	input  logic                        clk,
	input  logic                        arst_n,
	// page_number
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [fpr_pkg::IN_W-1:0]    s_tdata,
	// hit, frame_index, evicted_valid, evicted_page, fault_count, hit_count
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [fpr_pkg::RES_W-1:0]   m_tdata,
	// configuration
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [fpr_pkg::APB_AW-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	logic [fpr_pkg::CFG_W-1:0]     frames_in_use_q;
	logic [fpr_pkg::FIDX_W-1:0]    replace_ptr_q;
	logic [fpr_pkg::COUNT_W-1:0]   faults_q;
	logic [fpr_pkg::COUNT_W-1:0]   hits_q;
	logic                          m_tvalid_q;
	logic [fpr_pkg::RES_W-1:0]     m_tdata_q;

	logic [fpr_pkg::NCNT_W-1:0]    n_act;
	logic [fpr_pkg::NCNT_W-1:0]    ptr_ext;
	logic [fpr_pkg::NCNT_W-1:0]    victim_ext;
	logic [fpr_pkg::NCNT_W-1:0]    victim_inc;
	logic [fpr_pkg::FIDX_W-1:0]    victim;
	logic [fpr_pkg::FIDX_W-1:0]    next_ptr;
	logic [fpr_pkg::PAGE_BITS-1:0] page;
	logic                          accept;
	logic                          fault;
	logic [fpr_pkg::FIDX_W-1:0]    slot;
	logic [fpr_pkg::COUNT_W-1:0]   faults_nxt;
	logic [fpr_pkg::COUNT_W-1:0]   hits_nxt;
	logic                          cfg_wr;

	fpr_pkg::chain_t     chain [fpr_pkg::MAX_FRAMES+1];
	fpr_pkg::cell_ctrl_t ctrl  [fpr_pkg::MAX_FRAMES];

	// apb register access
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == fpr_pkg::REG_FRAMES_IN_USE);
	assign prdata = (paddr[2] == fpr_pkg::REG_FRAMES_IN_USE) ?
		{{(32 - fpr_pkg::CFG_W){1'b0}}, frames_in_use_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_in_use_q <= fpr_pkg::CFG_W'(fpr_pkg::MAX_FRAMES);
		end else if (cfg_wr) begin
			frames_in_use_q <= pwdata[fpr_pkg::CFG_W-1:0];
		end
	end

	// active frame count, clamped to one .. MAX_FRAMES
	always_comb begin
		n_act = fpr_pkg::NCNT_W'(frames_in_use_q);
		if (frames_in_use_q == '0) begin
			n_act = fpr_pkg::NCNT_W'(1);
		end else if (fpr_pkg::NCNT_W'(frames_in_use_q) >
			fpr_pkg::NCNT_W'(fpr_pkg::MAX_FRAMES)) begin
			n_act = fpr_pkg::NCNT_W'(fpr_pkg::MAX_FRAMES);
		end
	end

	// victim frame and the pointer after a fault
	assign ptr_ext    = fpr_pkg::NCNT_W'(replace_ptr_q);
	assign victim     = (ptr_ext < n_act) ? replace_ptr_q : '0;
	assign victim_ext = fpr_pkg::NCNT_W'(victim);
	assign victim_inc = victim_ext + fpr_pkg::NCNT_W'(1);
	assign next_ptr   = (victim_inc >= n_act) ? '0 : victim_inc[fpr_pkg::FIDX_W-1:0];

	// handshake: output register frees as its beat leaves
	assign page     = s_tdata[fpr_pkg::PAGE_BITS-1:0];
	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	// row of frame cells
	assign chain[0] = '0;

	for (genvar i = 0; i < fpr_pkg::MAX_FRAMES; i++) begin : g_cell
		assign ctrl[i].active = (fpr_pkg::NCNT_W'(i) < n_act);
		assign ctrl[i].victim = (victim == fpr_pkg::FIDX_W'(i));
		assign ctrl[i].load   = accept && !chain[fpr_pkg::MAX_FRAMES].found &&
			(victim == fpr_pkg::FIDX_W'(i));
		assign ctrl[i].idx    = fpr_pkg::FIDX_W'(i);

		fpr_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl[i]),
			.page      (page),
			.chain_in  (chain[i]),
			.chain_out (chain[i+1])
		);
	end

	assign fault = !chain[fpr_pkg::MAX_FRAMES].found;
	assign slot  = fault ? victim : chain[fpr_pkg::MAX_FRAMES].hit_slot;

	// saturating totals
	assign faults_nxt = (fault && faults_q != fpr_pkg::COUNT_MAX) ?
		faults_q + fpr_pkg::COUNT_W'(1) : faults_q;
	assign hits_nxt = (!fault && hits_q != fpr_pkg::COUNT_MAX) ?
		hits_q + fpr_pkg::COUNT_W'(1) : hits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			replace_ptr_q <= '0;
			faults_q      <= '0;
			hits_q        <= '0;
		end else if (accept) begin
			faults_q <= faults_nxt;
			hits_q   <= hits_nxt;
			if (fault) begin
				replace_ptr_q <= next_ptr;
			end
		end
	end

	// result beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (accept) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_tdata_q <= fpr_pkg::RES_W'({
				hits_nxt,
				faults_nxt,
				fault ? fpr_pkg::OUT_PG_W'(chain[fpr_pkg::MAX_FRAMES].ev_page) :
					fpr_pkg::OUT_PG_W'(0),
				fault && chain[fpr_pkg::MAX_FRAMES].ev_valid,
				fpr_pkg::OUT_IDX_W'(slot),
				!fault
			});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

@@ sv/fpr_checker.sv @@
// ----------------------------------------------------------------------------
// fpr_checker
// Port-level checks for the fifo page replacement block, bound to the top.
// ----------------------------------------------------------------------------
module fpr_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_tvalid,
	input logic                      s_tready,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [fpr_pkg::RES_W-1:0] m_tdata
);

	// a stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// a hit never reports an eviction
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> !m_tdata[4] && (m_tdata[20:5] == 16'd0))
		else $error("eviction reported on a hit");

	// no evicted page without the evicted flag
	a_evict_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[4] |-> (m_tdata[20:5] == 16'd0))
		else $error("evicted page set without evicted flag");

	// input side ready whenever the output register is free or draining
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_tvalid || m_tready) |-> s_tready)
		else $error("input stalled with free output register");

	// an accepted reference shows a result beat next cycle
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("no result beat after accepted reference");

endmodule

bind fifo_page_replacement fpr_checker u_fpr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
